FILE: sv/alarm_ring_snooze_controller_assert.svh
// Assertion macros for the alarm ring and snooze controller.
`ifndef ALARM_RING_SNOOZE_CONTROLLER_ASSERT_SVH
`define ALARM_RING_SNOOZE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ARSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ARSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/arsc_pkg.sv
// Package with types and constants shared by the alarm ring and snooze controller.
`timescale 1ns / 1ps
package arsc_pkg;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [19:0] RING_DURATION_RST   = 20'd60000;
    localparam logic [19:0] SNOOZE_INTERVAL_RST = 20'd300000;
    localparam logic [19:0] VIBRO_DELAY_RST     = 20'd30000;
    localparam logic [15:0] VIBRO_PERIOD_RST    = 16'd2000;
    localparam logic [2:0]  MAX_SNOOZES_RST     = 3'd3;

    localparam logic [19:0] ELAPSED_MAX = 20'hFFFFF;
    localparam logic [15:0] VIBRO_MAX   = 16'hFFFF;
    localparam logic [2:0]  COUNT_MAX   = 3'd7;

    typedef enum logic [2:0] {
        REG_ALARM_ENABLE    = 3'd0,
        REG_RING_DURATION   = 3'd1,
        REG_SNOOZE_INTERVAL = 3'd2,
        REG_VIBRO_DELAY     = 3'd3,
        REG_VIBRO_PERIOD    = 3'd4,
        REG_MAX_SNOOZES     = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic rtc_match;
        logic stop_press;
        logic snooze_press;
    } tick_t;

    typedef struct packed {
        logic ringing;
        logic sound_start;
        logic sound_stop;
        logic motor_on;
        logic snooze_on;
        logic sleep_request;
        logic [2:0] snoozes_used;
    } result_t;

    typedef struct packed {
        logic match;
        logic stop_req;
        logic snooze_req;
    } cmd_t;

    typedef struct packed {
        logic        alarm_enable;
        logic [19:0] ring_duration;
        logic [19:0] snooze_interval;
        logic [19:0] vibro_delay;
        logic [15:0] vibro_period;
        logic [2:0]  max_snoozes;
    } cfg_t;

endpackage

FILE: sv/arsc_front.sv
// Front end: accepts ticks, classifies them and queues commands for the back end.
`timescale 1ns / 1ps
module arsc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tick_valid,
    output logic            tick_stall,
    input  arsc_pkg::tick_t tick,
    output logic            cmd_valid,
    output arsc_pkg::cmd_t  cmd,
    input  logic            cmd_pop
);
    import arsc_pkg::*;

    cmd_t              q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              pop;
    cmd_t              cmd_in;

    assign tick_stall = (count_reg == QCNT_W'(QDEPTH));
    assign push       = tick_valid && !tick_stall;
    assign pop        = cmd_pop && (count_reg != '0);
    assign cmd_valid  = (count_reg != '0);
    assign cmd        = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        cmd_in.match      = tick.rtc_match;
        cmd_in.stop_req   = tick.stop_press;
        cmd_in.snooze_req = tick.snooze_press && !tick.stop_press;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

FILE: sv/arsc_back.sv
// Back end: ring, snooze and vibration state update and the result register.
`timescale 1ns / 1ps
`include "alarm_ring_snooze_controller_assert.svh"
module arsc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  arsc_pkg::cfg_t    cfg,
    input  logic              cmd_valid,
    input  arsc_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    output logic              result_valid,
    input  logic              result_stall,
    output arsc_pkg::result_t result
);
    import arsc_pkg::*;

    logic        ring_active_reg, ring_active_next;
    logic [19:0] ring_elapsed_reg, ring_elapsed_next;
    logic        snooze_active_reg, snooze_active_next;
    logic [19:0] snooze_elapsed_reg, snooze_elapsed_next;
    logic [2:0]  snooze_count_reg, snooze_count_next;
    logic        motor_level_reg, motor_level_next;
    logic [15:0] vibro_elapsed_reg, vibro_elapsed_next;
    logic        result_valid_reg;
    result_t     result_reg, result_next;
    logic        start, stop, sleep;

    assign cmd_pop      = cmd_valid && (!result_valid_reg || !result_stall);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        ring_elapsed_next   = (ring_elapsed_reg == ELAPSED_MAX) ? ELAPSED_MAX
                                                                : ring_elapsed_reg + 1'b1;
        snooze_elapsed_next = (snooze_elapsed_reg == ELAPSED_MAX) ? ELAPSED_MAX
                                                                  : snooze_elapsed_reg + 1'b1;
        vibro_elapsed_next  = (vibro_elapsed_reg == VIBRO_MAX) ? VIBRO_MAX
                                                               : vibro_elapsed_reg + 1'b1;
        ring_active_next    = ring_active_reg;
        snooze_active_next  = snooze_active_reg;
        snooze_count_next   = snooze_count_reg;
        motor_level_next    = motor_level_reg;
        start = 1'b0;
        stop  = 1'b0;
        sleep = 1'b0;

        if (cmd.match)
        begin
            snooze_count_next = '0;
            if (cfg.alarm_enable && !ring_active_next)
            begin
                ring_active_next  = 1'b1;
                ring_elapsed_next = '0;
                start = 1'b1;
            end
        end

        if (ring_active_next)
        begin
            if (cmd.stop_req)
            begin
                ring_active_next   = 1'b0;
                ring_elapsed_next  = '0;
                motor_level_next   = 1'b0;
                stop               = 1'b1;
                snooze_active_next = 1'b0;
            end
            else if ((ring_elapsed_next >= cfg.ring_duration) || cmd.snooze_req)
            begin
                ring_active_next  = 1'b0;
                ring_elapsed_next = '0;
                motor_level_next  = 1'b0;
                stop              = 1'b1;
                if (snooze_count_next < cfg.max_snoozes)
                begin
                    snooze_active_next  = 1'b1;
                    snooze_elapsed_next = '0;
                end
                else
                begin
                    snooze_active_next = 1'b0;
                    sleep = 1'b1;
                end
            end
            if (ring_active_next && (ring_elapsed_next > cfg.vibro_delay) &&
                (vibro_elapsed_next > cfg.vibro_period))
            begin
                motor_level_next   = !motor_level_next;
                vibro_elapsed_next = '0;
            end
        end

        if (snooze_active_next && (snooze_elapsed_next > cfg.snooze_interval))
        begin
            if (cfg.alarm_enable && !ring_active_next)
            begin
                ring_active_next  = 1'b1;
                ring_elapsed_next = '0;
                start = 1'b1;
            end
            snooze_elapsed_next = '0;
            snooze_count_next   = (snooze_count_next == COUNT_MAX) ? COUNT_MAX
                                                                   : snooze_count_next + 1'b1;
        end

        result_next.ringing       = ring_active_next;
        result_next.sound_start   = start;
        result_next.sound_stop    = stop;
        result_next.motor_on      = motor_level_next;
        result_next.snooze_on     = snooze_active_next;
        result_next.sleep_request = sleep;
        result_next.snoozes_used  = snooze_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_active_reg    <= 1'b0;
            ring_elapsed_reg   <= '0;
            snooze_active_reg  <= 1'b0;
            snooze_elapsed_reg <= '0;
            snooze_count_reg   <= '0;
            motor_level_reg    <= 1'b0;
            vibro_elapsed_reg  <= '0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                ring_active_reg    <= ring_active_next;
                ring_elapsed_reg   <= ring_elapsed_next;
                snooze_active_reg  <= snooze_active_next;
                snooze_elapsed_reg <= snooze_elapsed_next;
                snooze_count_reg   <= snooze_count_next;
                motor_level_reg    <= motor_level_next;
                vibro_elapsed_reg  <= vibro_elapsed_next;
                result_valid_reg   <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            result_reg <= result_next;
        end
    end

    `ARSC_ASSERT_NOW(a_motor_idle, !ring_active_reg, !motor_level_reg,
        "Motor on while not ringing.")
    `ARSC_ASSERT_NOW(a_sleep_no_snooze, result_valid_reg && result_reg.sleep_request,
        !result_reg.snooze_on, "Sleep request with snooze still active.")
    `ARSC_ASSERT_NOW(a_stop_motor_off, result_valid_reg && result_reg.sound_stop,
        !result_reg.motor_on, "Motor still on in the tick ringing ended.")
    `ARSC_ASSERT_NEXT(a_pop_updates, cmd_pop,
        result_valid_reg && (result_reg.ringing == ring_active_reg),
        "Result does not match the updated ring state.")

endmodule

FILE: sv/alarm_ring_snooze_controller.sv
// Top level of the alarm ring and snooze controller with its configuration registers.
// A tick is queued in the front end, then its result is registered in the back end.
// Throughput: one tick per cycle unless a result stall holds the back end.
// A two-entry queue between front and back end buffers ticks while the result stalls.
// Reset is asynchronous, active low; it clears control state and loads register defaults.
`timescale 1ns / 1ps
module alarm_ring_snooze_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tick_valid,
    output logic              tick_stall,
    input  arsc_pkg::tick_t   tick,
    output logic              result_valid,
    input  logic              result_stall,
    output arsc_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [19:0]       cfg_data
);
    import arsc_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (reg_index_t'(cfg_index))
                REG_ALARM_ENABLE:    cfg_next.alarm_enable    = cfg_data[0];
                REG_RING_DURATION:   cfg_next.ring_duration   = cfg_data;
                REG_SNOOZE_INTERVAL: cfg_next.snooze_interval = cfg_data;
                REG_VIBRO_DELAY:     cfg_next.vibro_delay     = cfg_data;
                REG_VIBRO_PERIOD:    cfg_next.vibro_period    = cfg_data[15:0];
                REG_MAX_SNOOZES:     cfg_next.max_snoozes     = cfg_data[2:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alarm_enable    <= 1'b0;
            cfg_reg.ring_duration   <= RING_DURATION_RST;
            cfg_reg.snooze_interval <= SNOOZE_INTERVAL_RST;
            cfg_reg.vibro_delay     <= VIBRO_DELAY_RST;
            cfg_reg.vibro_period    <= VIBRO_PERIOD_RST;
            cfg_reg.max_snoozes     <= MAX_SNOOZES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    arsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick       (tick),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    arsc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

FILE: dv/alarm_ring_snooze_controller_tb.sv
// Self-checking testbench for the alarm ring and snooze controller.
`timescale 1ns / 1ps
module alarm_ring_snooze_controller_tb;
    import arsc_pkg::*;

    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam int RANDOM_PHASES   = 10;
    localparam int TICKS_PER_PHASE = 72;
    localparam int DRAIN_CYCLES    = 8;

    typedef enum int {SET_HIGHEST, SET_LOWEST, SET_RANDOM} setting_kind_t;

    typedef struct {
        logic        is_write;
        logic [2:0]  reg_idx;
        logic [19:0] reg_data;
        tick_t       stim;
        logic        pinned;
        result_t     pinned_result;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        tick_valid = 1'b0;
    logic        tick_stall;
    tick_t       tick = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [19:0] cfg_data = '0;

    cfg_t        alarm_cfg;
    logic        ring_live;
    logic        snooze_live;
    logic        motor_drive;
    logic [19:0] ring_ms;
    logic [19:0] snooze_ms;
    logic [15:0] motor_ms;
    logic [2:0]  snoozes_taken;

    result_t     expected_results[$];
    plan_row_t   directed_plan[$];

    int          mismatch_count = 0;
    int          ticks_sent = 0;
    int          results_checked = 0;
    int          rings_seen = 0;
    int          sleeps_seen = 0;
    int          settings_done = 0;
    int          burst_left = 0;
    logic [2:0]  peak_count = '0;

    logic [7:0]  stall_pattern = '0;
    logic [4:0]  stall_step = '0;

    alarm_ring_snooze_controller DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic result_t alarm_tick(input tick_t t);
        result_t r;
        logic    start_p;
        logic    stop_p;
        logic    sleep_p;
        logic    ending;
        start_p = 1'b0;
        stop_p = 1'b0;
        sleep_p = 1'b0;
        if (ring_ms != ELAPSED_MAX)
            ring_ms = ring_ms + 20'd1;
        if (snooze_ms != ELAPSED_MAX)
            snooze_ms = snooze_ms + 20'd1;
        if (motor_ms != VIBRO_MAX)
            motor_ms = motor_ms + 16'd1;

        if (t.rtc_match)
        begin
            snoozes_taken = '0;
            if (alarm_cfg.alarm_enable && !ring_live)
            begin
                ring_live = 1'b1;
                ring_ms = '0;
                start_p = 1'b1;
            end
        end

        if (ring_live)
        begin
            ending = t.stop_press || t.snooze_press || ring_ms >= alarm_cfg.ring_duration;
            if (ending)
            begin
                ring_live = 1'b0;
                ring_ms = '0;
                motor_drive = 1'b0;
                stop_p = 1'b1;
                if (t.stop_press)
                    snooze_live = 1'b0;
                else if (snoozes_taken < alarm_cfg.max_snoozes)
                begin
                    snooze_live = 1'b1;
                    snooze_ms = '0;
                end
                else
                begin
                    snooze_live = 1'b0;
                    sleep_p = 1'b1;
                end
            end
            if (ring_live && ring_ms > alarm_cfg.vibro_delay
                && motor_ms > alarm_cfg.vibro_period)
            begin
                motor_drive = ~motor_drive;
                motor_ms = '0;
            end
        end

        // An expired wait restarts and counts even when it cannot ring.
        if (snooze_live && snooze_ms > alarm_cfg.snooze_interval)
        begin
            if (alarm_cfg.alarm_enable && !ring_live)
            begin
                ring_live = 1'b1;
                ring_ms = '0;
                start_p = 1'b1;
            end
            snooze_ms = '0;
            if (snoozes_taken != COUNT_MAX)
                snoozes_taken = snoozes_taken + 3'd1;
        end

        r.ringing = ring_live;
        r.sound_start = start_p;
        r.sound_stop = stop_p;
        r.motor_on = motor_drive;
        r.snooze_on = snooze_live;
        r.sleep_request = sleep_p;
        r.snoozes_used = snoozes_taken;
        return r;
    endfunction

    function automatic void plan_write(input logic [2:0] idx, input logic [19:0] data);
        plan_row_t row;
        row.is_write = 1'b1;
        row.reg_idx = idx;
        row.reg_data = data;
        row.stim = '0;
        row.pinned = 1'b0;
        row.pinned_result = '0;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_pinned(input tick_t t, input logic pinned, input result_t want);
        plan_row_t row;
        row.is_write = 1'b0;
        row.reg_idx = '0;
        row.reg_data = '0;
        row.stim = t;
        row.pinned = pinned;
        row.pinned_result = want;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_tick(input tick_t t);
        plan_pinned(t, 1'b0, '0);
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        if ($urandom_range(0, 9) == 0)
            t = tick_t'(3'($urandom_range(0, 7)));
        else
        begin
            t.rtc_match = ($urandom_range(0, 39) == 0);
            t.stop_press = ($urandom_range(0, 19) == 0);
            t.snooze_press = ($urandom_range(0, 9) == 0);
        end
        return t;
    endfunction

    task automatic check_result(input result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            $error("result with nothing expected: %b", got);
            mismatch_count++;
        end
        else
        begin
            want = expected_results.pop_front();
            results_checked++;
            if (got.ringing !== want.ringing)
            begin
                $error("ringing: expected %0d, actual %0d", want.ringing, got.ringing);
                mismatch_count++;
            end
            if (got.sound_start !== want.sound_start)
            begin
                $error("sound_start: expected %0d, actual %0d",
                       want.sound_start, got.sound_start);
                mismatch_count++;
            end
            if (got.sound_stop !== want.sound_stop)
            begin
                $error("sound_stop: expected %0d, actual %0d", want.sound_stop, got.sound_stop);
                mismatch_count++;
            end
            if (got.motor_on !== want.motor_on)
            begin
                $error("motor_on: expected %0d, actual %0d", want.motor_on, got.motor_on);
                mismatch_count++;
            end
            if (got.snooze_on !== want.snooze_on)
            begin
                $error("snooze_on: expected %0d, actual %0d", want.snooze_on, got.snooze_on);
                mismatch_count++;
            end
            if (got.sleep_request !== want.sleep_request)
            begin
                $error("sleep_request: expected %0d, actual %0d",
                       want.sleep_request, got.sleep_request);
                mismatch_count++;
            end
            if (got.snoozes_used !== want.snoozes_used)
            begin
                $error("snoozes_used: expected %0d, actual %0d",
                       want.snoozes_used, got.snoozes_used);
                mismatch_count++;
            end
            if (want.sound_start)
                rings_seen++;
            if (want.sleep_request)
                sleeps_seen++;
            if (want.snoozes_used > peak_count)
                peak_count = want.snoozes_used;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            check_result(result);
        stall_step <= stall_step + 5'd1;
        if (stall_step == '0)
        begin
            case ($urandom_range(0, 3))
                0: stall_pattern <= 8'h00;
                1: stall_pattern <= 8'($urandom);
                2: stall_pattern <= 8'($urandom & $urandom);
                default: stall_pattern <= 8'($urandom | $urandom);
            endcase
        end
        result_stall <= stall_pattern[stall_step[2:0]];
    end

    task automatic send_tick(input tick_t t, input logic pinned, input result_t pinned_value);
        result_t predicted;
        tick_valid <= 1'b1;
        tick <= t;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        predicted = alarm_tick(t);
        expected_results.push_back(pinned ? pinned_value : predicted);
        ticks_sent++;
    endtask

    task automatic burst_gap();
        if (burst_left == 0)
        begin
            tick_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    task automatic drain_ticks();
        tick_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_ALARM_ENABLE:    alarm_cfg.alarm_enable = data[0];
            REG_RING_DURATION:   alarm_cfg.ring_duration = data;
            REG_SNOOZE_INTERVAL: alarm_cfg.snooze_interval = data;
            REG_VIBRO_DELAY:     alarm_cfg.vibro_delay = data;
            REG_VIBRO_PERIOD:    alarm_cfg.vibro_period = data[15:0];
            REG_MAX_SNOOZES:     alarm_cfg.max_snoozes = data[2:0];
            default: ;
        endcase
    endtask

    task automatic program_settings(input setting_kind_t kind);
        logic [19:0] en;
        logic [19:0] dur;
        logic [19:0] wait_ms;
        logic [19:0] dly;
        logic [19:0] per;
        logic [19:0] lim;
        case (kind)
            SET_HIGHEST:
            begin
                en = 20'd1;
                dur = ELAPSED_MAX;
                wait_ms = ELAPSED_MAX;
                dly = ELAPSED_MAX;
                per = {4'd0, VIBRO_MAX};
                lim = {17'd0, COUNT_MAX};
            end
            SET_LOWEST:
            begin
                en = 20'd1;
                dur = 20'd1;
                wait_ms = 20'd1;
                dly = 20'd0;
                per = 20'd1;
                lim = 20'd0;
            end
            default:
            begin
                en = 20'($urandom);
                en[0] = ($urandom_range(0, 5) != 0);
                dur = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 12));
                wait_ms = ($urandom_range(0, 9) == 0) ? 20'($urandom)
                                                      : 20'($urandom_range(0, 15));
                dly = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 10));
                per = ($urandom_range(0, 9) == 0) ? 20'($urandom)
                                                  : {4'($urandom), 16'($urandom_range(0, 4))};
                lim = {17'($urandom), 3'($urandom)};
            end
        endcase
        drain_ticks();
        write_reg(REG_ALARM_ENABLE, en);
        write_reg(REG_RING_DURATION, dur);
        write_reg(REG_SNOOZE_INTERVAL, wait_ms);
        write_reg(REG_VIBRO_DELAY, dly);
        write_reg(REG_VIBRO_PERIOD, per);
        write_reg(REG_MAX_SNOOZES, lim);
        write_reg(REG_SPARE_LO, 20'($urandom));
        write_reg(REG_SPARE_HI, 20'($urandom));
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    initial
    begin
        plan_row_t     row;
        setting_kind_t kind;
        int            gaps_on;

        alarm_cfg.alarm_enable = 1'b0;
        alarm_cfg.ring_duration = RING_DURATION_RST;
        alarm_cfg.snooze_interval = SNOOZE_INTERVAL_RST;
        alarm_cfg.vibro_delay = VIBRO_DELAY_RST;
        alarm_cfg.vibro_period = VIBRO_PERIOD_RST;
        alarm_cfg.max_snoozes = MAX_SNOOZES_RST;
        ring_live = 1'b0;
        snooze_live = 1'b0;
        motor_drive = 1'b0;
        ring_ms = '0;
        snooze_ms = '0;
        motor_ms = '0;
        snoozes_taken = '0;

        // Tick bits are match, stop, snooze; result bits follow the package order.
        plan_pinned(tick_t'(3'b000), 1'b1, result_t'(9'b0_0_0_0_0_0_000));
        plan_pinned(tick_t'(3'b111), 1'b1, result_t'(9'b0_0_0_0_0_0_000));
        plan_pinned(tick_t'(3'b011), 1'b1, result_t'(9'b0_0_0_0_0_0_000));
        plan_write(REG_ALARM_ENABLE, 20'hFFFFF);
        plan_write(REG_RING_DURATION, 20'd3);
        plan_write(REG_SNOOZE_INTERVAL, 20'd2);
        plan_write(REG_VIBRO_DELAY, 20'd0);
        plan_write(REG_VIBRO_PERIOD, 20'hF0001);
        plan_write(REG_MAX_SNOOZES, 20'h00009);
        plan_write(REG_SPARE_LO, 20'd0);
        plan_write(REG_SPARE_HI, 20'hFFFFF);
        plan_pinned(tick_t'(3'b100), 1'b1, result_t'(9'b1_1_0_0_0_0_000));
        repeat (6) plan_tick(tick_t'(3'b000));
        plan_tick(tick_t'(3'b001));
        plan_pinned(tick_t'(3'b110), 1'b1, result_t'(9'b0_1_1_0_0_0_000));
        plan_tick(tick_t'(3'b100));
        plan_tick(tick_t'(3'b011));
        plan_tick(tick_t'(3'b100));
        plan_tick(tick_t'(3'b100));
        plan_write(REG_RING_DURATION, 20'd0);
        plan_write(REG_MAX_SNOOZES, 20'd7);
        plan_write(REG_SNOOZE_INTERVAL, 20'd1);
        plan_tick(tick_t'(3'b100));
        repeat (4) plan_tick(tick_t'(3'b000));
        plan_tick(tick_t'(3'b100));
        plan_write(REG_ALARM_ENABLE, 20'hFFFFE);
        repeat (2) plan_tick(tick_t'(3'b000));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < directed_plan.size(); i++)
        begin
            row = directed_plan[i];
            if (row.is_write)
            begin
                drain_ticks();
                write_reg(row.reg_idx, row.reg_data);
            end
            else
            begin
                cfg_valid <= 1'b0;
                send_tick(row.stim, row.pinned, row.pinned_result);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                kind = SET_HIGHEST;
            else if (p == 1)
                kind = SET_LOWEST;
            else
                kind = SET_RANDOM;
            program_settings(kind);
            gaps_on = ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(1, 24);
            repeat (TICKS_PER_PHASE)
            begin
                if (gaps_on)
                    burst_gap();
                send_tick(random_tick(), 1'b0, '0);
            end
        end

        drain_ticks();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d ticks under %0d register settings, %0d results compared.",
                 ticks_sent, settings_done, results_checked);
        $display("It saw %0d ring starts, %0d sleep requests and a snooze count of up to %0d.",
                 rings_seen, sleeps_seen, peak_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
